### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, included by the key keeper core top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge of clk, idle while reset is low.
`define AST_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that the antecedent implies the consequent in the next cycle.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_CLK(lbl, prop)
`define AST_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/tkrk_pkg.sv
// ----------------------------------------------------------------------------
// tkrk_pkg
// Shared constants and controller/datapath interface types of the key keeper.
// ----------------------------------------------------------------------------
package tkrk_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int LIMIT_W  = 7;
  localparam int SLOT_W   = 6;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(64);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;    // capture the incoming key
    logic             fill;    // store key in the next free slot
    logic             rd_en;   // read one slot for the minimum scan
    logic [IDX_W-1:0] rd_idx;  // slot to read
    logic             decide;  // compare against the minimum and update
  } tkrk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             full;      // fill count has reached the limit in use
    logic [IDX_W-1:0] lim_last;  // highest slot index in use
  } tkrk_stat_t;

endpackage

### rtl/core/tkrk_ram.sv
// ----------------------------------------------------------------------------
// tkrk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkrk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/tkrk_dp.sv
// ----------------------------------------------------------------------------
// tkrk_dp
// Key store, fill count, limit register, minimum tracker and result registers.
// ----------------------------------------------------------------------------
module tkrk_dp
  import tkrk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [LIMIT_W-1:0]      cfg_wdata,
  input  logic signed [KEY_W-1:0] in_key,
  input  tkrk_cmd_t               cmd,
  output tkrk_stat_t              stat,
  output logic                    out_valid,
  output logic                    out_accepted,
  output logic [SLOT_W-1:0]       out_slot
);

  logic [LIMIT_W-1:0]      sample_limit_r;
  logic [CNT_W-1:0]        filled_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] min_r;
  logic [IDX_W-1:0]        min_idx_r;
  logic                    rd_valid_r;
  logic [IDX_W-1:0]        rd_idx_q_r;
  logic                    out_valid_r;
  logic                    out_accepted_r;
  logic [SLOT_W-1:0]       out_slot_r;

  logic [CNT_W-1:0]        lim;
  logic signed [KEY_W-1:0] rd_data;
  logic                    take;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [KEY_W-1:0]        ram_wdata;

  // Clamp the limit into 1..CAPACITY.
  always_comb begin
    if (sample_limit_r == '0) begin
      lim = CNT_W'(1);
    end else if (int'(sample_limit_r) > CAPACITY) begin
      lim = CNT_W'(CAPACITY);
    end else begin
      lim = CNT_W'(sample_limit_r);
    end
  end

  assign stat.full     = (filled_r >= lim);
  assign stat.lim_last = IDX_W'(lim - CNT_W'(1));

  assign take      = (key_r > min_r);
  assign ram_we    = cmd.fill | (cmd.decide & take);
  assign ram_waddr = cmd.fill ? IDX_W'(filled_r) : min_idx_r;
  assign ram_wdata = cmd.fill ? in_key : key_r;

  tkrk_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_limit_r <= LIMIT_RST;
      filled_r       <= '0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        sample_limit_r <= cfg_wdata;
      end
      if (cmd.fill) begin
        filled_r <= filled_r + CNT_W'(1);
      end
      rd_valid_r  <= cmd.rd_en;
      out_valid_r <= cmd.fill | cmd.decide;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
    end
    rd_idx_q_r <= cmd.rd_idx;
    // Strict less-than keeps the lowest index on ties.
    if (rd_valid_r && ((rd_idx_q_r == '0) || (rd_data < min_r))) begin
      min_r     <= rd_data;
      min_idx_r <= rd_idx_q_r;
    end
    if (cmd.fill) begin
      out_accepted_r <= 1'b1;
      out_slot_r     <= SLOT_W'(filled_r);
    end else if (cmd.decide) begin
      out_accepted_r <= take;
      out_slot_r     <= take ? SLOT_W'(min_idx_r) : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_accepted_r;
  assign out_slot     = out_slot_r;

endmodule

### rtl/core/tkrk_ctrl.sv
// ----------------------------------------------------------------------------
// tkrk_ctrl
// Sequencer: fill directly, or scan the slots for the minimum and decide.
// ----------------------------------------------------------------------------
module tkrk_ctrl
  import tkrk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  tkrk_stat_t stat,
  output tkrk_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DECIDE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             busy_r, busy_nxt;
  logic             accept;

  assign accept = start & (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    cmd        = '0;
    cmd.rd_idx = rd_idx_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          if (stat.full) begin
            state_nxt  = S_SCAN;
            rd_idx_nxt = '0;
          end else begin
            cmd.fill = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (rd_idx_r == stat.lim_last) begin
          state_nxt = S_WAIT;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_idx_r <= '0;
      busy_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      busy_r   <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

### rtl/core/top_k_reservoir_key_keeper_core.sv
// ----------------------------------------------------------------------------
// top_k_reservoir_key_keeper_core
// Keeps the largest signed Q16.16 keys seen, one per reservoir slot.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Transaction taken when
//   input     start, busy, in_key            start high and busy low
//   result    out_valid, out_accepted,       out_valid high (one cycle)
//             out_slot
//   config    cfg_we, cfg_wdata              cfg_we high
//
// Cycles: while the reservoir is filling, a transaction is stored at its
// accept edge and its result shows in the next cycle; busy stays low, so
// fills run back to back. Once full, busy is high through the scan, wait
// and decide states while the key store (one read port) is scanned one
// slot a cycle for the minimum; the result shows in the first cycle busy
// is low again.
// Reset (rst_n low, synchronous) empties the fill count and sets the limit
// to 64; the key store is not cleared. The receiver cannot stall results.
//
module top_k_reservoir_key_keeper_core
  import tkrk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  output logic                    out_accepted,
  output logic [SLOT_W-1:0]       out_slot,
  input  logic                    cfg_we,
  input  logic [LIMIT_W-1:0]      cfg_wdata
);

`include "assert_macros.svh"

  tkrk_cmd_t  cmd;
  tkrk_stat_t stat;

  // Sequence each transaction: fill, or scan and decide.
  tkrk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold keys, track the minimum and drive the result registers.
  tkrk_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_key       (in_key),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_accepted (out_accepted),
    .out_slot     (out_slot)
  );

  // A transaction taken while filling is stored and reported next cycle.
  `AST_NEXT(a_fill_result, start && !busy && !stat.full, out_valid && out_accepted)
  // A transaction taken while full starts the scan.
  `AST_NEXT(a_full_scan, start && !busy && stat.full, busy && !out_valid)
  // A rejected key reports slot zero.
  `AST_CLK(a_reject_slot, !(out_valid && !out_accepted) || (out_slot == '0))
  // No result is shown while the scan is still running.
  `AST_CLK(a_no_result_busy, !(busy && out_valid))

endmodule
